// ----- rtl/qsah_pkg.sv -----
// shared types, widths and codes for the quality score alert block
package qsah_pkg;

    localparam int CONF_W  = 15;
    localparam int SCORE_W = 7;
    localparam int CNT_W   = 10;
    localparam int STEP_W  = 8;
    localparam int PROD_W  = 15;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 10;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 40;

    localparam int MUL_STEPS = SCORE_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CONF_W-1:0]  CONF_FULL  = 15'd25600;
    localparam logic [SCORE_W-1:0] SCORE_FULL = 7'd100;

    localparam logic [SCORE_W-1:0] RST_SCORE_LOW  = 7'd40;
    localparam logic [SCORE_W-1:0] RST_SCORE_HIGH = 7'd60;
    localparam logic [CNT_W-1:0]   RST_COUNT_LIM  = 10'd10;
    localparam logic [STEP_W-1:0]  RST_STEP_UP    = 8'd3;
    localparam logic [STEP_W-1:0]  RST_STEP_DOWN  = 8'd1;

    typedef enum logic [IDX_W-1:0] {
        REG_SCORE_LOW  = 3'd0,
        REG_SCORE_HIGH = 3'd1,
        REG_COUNT_LIM  = 3'd2,
        REG_STEP_UP    = 3'd3,
        REG_STEP_DOWN  = 3'd4,
        REG_LEARN      = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DEGRADED = 2'd1,
        EV_VALID    = 2'd2,
        EV_DISCONN  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } top_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV
    } div_state_t;

    typedef struct packed {
        logic [STEP_W-1:0]  mcand;
        logic [SCORE_W-1:0] mplier;
        logic [SCORE_W-1:0] divisor;
    } arith_req_t;

endpackage

// ----- rtl/qsah_serdiv.sv -----
// bit-serial unit: rounded quotient (mcand*mplier + divisor/2) / divisor
module qsah_serdiv
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  qsah_pkg::arith_req_t          req,
    output logic                          done,
    output logic [qsah_pkg::PROD_W-1:0]   quot
);

    qsah_pkg::div_state_t st_reg, st_next;
    logic [qsah_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [qsah_pkg::PROD_W-1:0]     acc_reg, acc_next;
    logic [qsah_pkg::PROD_W-1:0]     mcand_reg, mcand_next;
    logic [qsah_pkg::SCORE_W-1:0]    mplier_reg, mplier_next;
    logic [qsah_pkg::SCORE_W-1:0]    div_reg, div_next;
    logic [qsah_pkg::SCORE_W-1:0]    rem_reg, rem_next;
    logic                            done_reg, done_next;
    logic [qsah_pkg::SCORE_W:0]      trial;
    logic [qsah_pkg::SCORE_W:0]      diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= qsah_pkg::DV_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
    end

    assign trial = {rem_reg, acc_reg[qsah_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;
        unique case (st_reg)
            qsah_pkg::DV_IDLE:
            begin
                if (start)
                begin
                    // rounding half seeds the accumulator
                    acc_next    = {{(qsah_pkg::PROD_W-qsah_pkg::SCORE_W){1'b0}},
                                   (req.divisor >> 1)};
                    mcand_next  = {{(qsah_pkg::PROD_W-qsah_pkg::STEP_W){1'b0}}, req.mcand};
                    mplier_next = req.mplier;
                    div_next    = req.divisor;
                    cnt_next    = '0;
                    st_next     = qsah_pkg::DV_MUL;
                end
            end
            qsah_pkg::DV_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == qsah_pkg::STEP_CNT_W'(qsah_pkg::MUL_STEPS - 1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    st_next  = qsah_pkg::DV_DIV;
                end
            end
            qsah_pkg::DV_DIV:
            begin
                // restoring division, one quotient bit per beat of the clock
                if (!diff[qsah_pkg::SCORE_W])
                begin
                    rem_next = diff[qsah_pkg::SCORE_W-1:0];
                    acc_next = {acc_reg[qsah_pkg::PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[qsah_pkg::SCORE_W-1:0];
                    acc_next = {acc_reg[qsah_pkg::PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == qsah_pkg::STEP_CNT_W'(qsah_pkg::DIV_STEPS - 1))
                begin
                    cnt_next  = '0;
                    done_next = 1'b1;
                    st_next   = qsah_pkg::DV_IDLE;
                end
            end
            default:
            begin
                st_next = qsah_pkg::DV_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule

// ----- rtl/quality_score_alert_hysteresis.sv -----
// top level: confidence clamp, alert counter with hysteretic invalid flag
//
// channel   dir   payload
// s_*       in    tdata[15:0] confidence_q8; tuser[0] cmd, tuser[1] frame_ok
// m_*       out   tdata: event_kind, alert_count, sensor_bad, score_out, conf_clamped
// cfg_*     in    cfg_idx selects register, cfg_data value, cfg_we strobe
//
// a counting frame raises m_tvalid after the serial multiply and the serial divide in qsah_serdiv,
// then ST_CALC updates the counter and ST_DONE loads the output register.
// restart, learn mode and skipped frames go straight to ST_DONE, which loads the output register.
// one item at a time; the next beat is taken while a result waits in the output register.
// reset: counter at 10, flag invalid, registers at their defaults.
module quality_score_alert_hysteresis
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [qsah_pkg::IN_W-1:0]     s_tdata,   // confidence_q8
    input  logic [1:0]                    s_tuser,   // cmd, frame_ok
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [qsah_pkg::OUT_W-1:0]    m_tdata,   // event_kind, alert_count, sensor_bad,
                                                     // score_out, conf_clamped, zero pad
    input  logic                          cfg_we,
    input  logic [qsah_pkg::IDX_W-1:0]    cfg_idx,
    input  logic [qsah_pkg::CFG_W-1:0]    cfg_data
);

    logic [qsah_pkg::SCORE_W-1:0] score_low_reg;
    logic [qsah_pkg::SCORE_W-1:0] score_high_reg;
    logic [qsah_pkg::CNT_W-1:0]   count_lim_reg;
    logic [qsah_pkg::STEP_W-1:0]  step_up_reg;
    logic [qsah_pkg::STEP_W-1:0]  step_down_reg;
    logic                         learn_reg;

    qsah_pkg::top_state_t         st_reg, st_next;
    logic [qsah_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         bad_reg, bad_next;
    qsah_pkg::event_t             ev_reg, ev_next;
    logic [qsah_pkg::SCORE_W-1:0] score_reg, score_next;
    logic [qsah_pkg::CONF_W-1:0]  conf_reg, conf_next;
    logic                         low_reg, low_next;
    logic                         high_reg, high_next;
    logic                         out_valid_reg, out_valid_next;
    logic [qsah_pkg::OUT_W-1:0]   out_data_reg, out_data_next;

    logic                         accept;
    logic [qsah_pkg::CONF_W-1:0]  conf_in;
    logic [qsah_pkg::SCORE_W-1:0] score_in;
    logic                         low_in;
    logic                         high_in;
    logic                         unit_start;
    qsah_pkg::arith_req_t         unit_req;
    logic                         unit_done;
    logic [qsah_pkg::PROD_W-1:0]  unit_quot;
    logic [qsah_pkg::PROD_W-1:0]  step;
    logic [qsah_pkg::PROD_W:0]    sum;
    logic [qsah_pkg::PROD_W-1:0]  count_ext;
    logic [qsah_pkg::CNT_W-1:0]   count_upd;

    qsah_serdiv u_serdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .req   (unit_req),
        .done  (unit_done),
        .quot  (unit_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_low_reg  <= qsah_pkg::RST_SCORE_LOW;
            score_high_reg <= qsah_pkg::RST_SCORE_HIGH;
            count_lim_reg  <= qsah_pkg::RST_COUNT_LIM;
            step_up_reg    <= qsah_pkg::RST_STEP_UP;
            step_down_reg  <= qsah_pkg::RST_STEP_DOWN;
            learn_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                qsah_pkg::REG_SCORE_LOW:  score_low_reg  <= cfg_data[qsah_pkg::SCORE_W-1:0];
                qsah_pkg::REG_SCORE_HIGH: score_high_reg <= cfg_data[qsah_pkg::SCORE_W-1:0];
                qsah_pkg::REG_COUNT_LIM:  count_lim_reg  <= cfg_data[qsah_pkg::CNT_W-1:0];
                qsah_pkg::REG_STEP_UP:    step_up_reg    <= cfg_data[qsah_pkg::STEP_W-1:0];
                qsah_pkg::REG_STEP_DOWN:  step_down_reg  <= cfg_data[qsah_pkg::STEP_W-1:0];
                qsah_pkg::REG_LEARN:      learn_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= qsah_pkg::ST_IDLE;
            count_reg     <= qsah_pkg::RST_COUNT_LIM;
            bad_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            count_reg     <= count_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg       <= ev_next;
        score_reg    <= score_next;
        conf_reg     <= conf_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        out_data_reg <= out_data_next;
    end

    // clamp to 0..100 percent in q8.8
    always_comb
    begin
        if (s_tdata[qsah_pkg::IN_W-1])
        begin
            conf_in = '0;
        end
        else if (s_tdata[qsah_pkg::CONF_W-1:0] > qsah_pkg::CONF_FULL)
        begin
            conf_in = qsah_pkg::CONF_FULL;
        end
        else
        begin
            conf_in = s_tdata[qsah_pkg::CONF_W-1:0];
        end
    end

    assign score_in = conf_in[qsah_pkg::CONF_W-1:8];
    assign low_in   = score_in < score_low_reg;
    assign high_in  = score_in > score_high_reg;
    assign s_tready = (st_reg == qsah_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (low_in)
        begin
            unit_req.mcand   = step_up_reg;
            unit_req.mplier  = score_low_reg - score_in;
            unit_req.divisor = score_low_reg;
        end
        else
        begin
            unit_req.mcand   = step_down_reg;
            unit_req.mplier  = score_in - score_high_reg;
            unit_req.divisor = qsah_pkg::SCORE_FULL - score_high_reg;
        end
    end

    assign unit_start = accept && !s_tuser[0] && s_tuser[1] && !learn_reg && (low_in || high_in);

    // step is at least one
    assign step      = (unit_quot == '0) ? qsah_pkg::PROD_W'(1) : unit_quot;
    assign count_ext = {{(qsah_pkg::PROD_W-qsah_pkg::CNT_W){1'b0}}, count_reg};
    assign sum       = {1'b0, count_ext} + {1'b0, step};

    always_comb
    begin
        if (low_reg)
        begin
            if (sum < {{(qsah_pkg::PROD_W+1-qsah_pkg::CNT_W){1'b0}}, count_lim_reg})
            begin
                count_upd = sum[qsah_pkg::CNT_W-1:0];
            end
            else
            begin
                count_upd = count_lim_reg;
            end
        end
        else if (count_ext > step)
        begin
            count_upd = count_reg - step[qsah_pkg::CNT_W-1:0];
        end
        else
        begin
            count_upd = '0;
        end
    end

    always_comb
    begin
        st_next        = st_reg;
        count_next     = count_reg;
        bad_next       = bad_reg;
        ev_next        = ev_reg;
        score_next     = score_reg;
        conf_next      = conf_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (st_reg)
            qsah_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ev_next = qsah_pkg::EV_NONE;
                    st_next = qsah_pkg::ST_DONE;
                    if (s_tuser[0])
                    begin
                        // restart: reseed counter, force invalid
                        count_next = count_lim_reg;
                        bad_next   = 1'b1;
                        score_next = '0;
                        conf_next  = '0;
                        if (!bad_reg)
                        begin
                            ev_next = qsah_pkg::EV_DISCONN;
                        end
                    end
                    else
                    begin
                        score_next = score_in;
                        conf_next  = conf_in;
                        low_next   = low_in;
                        high_next  = high_in;
                        if (unit_start)
                        begin
                            st_next = qsah_pkg::ST_CALC;
                        end
                    end
                end
            end
            qsah_pkg::ST_CALC:
            begin
                if (unit_done)
                begin
                    count_next = count_upd;
                    st_next    = qsah_pkg::ST_DONE;
                    if (low_reg && (count_upd >= count_lim_reg) && !bad_reg)
                    begin
                        bad_next = 1'b1;
                        ev_next  = qsah_pkg::EV_DEGRADED;
                    end
                    else if (high_reg && (count_upd == '0) && bad_reg)
                    begin
                        bad_next = 1'b0;
                        ev_next  = qsah_pkg::EV_VALID;
                    end
                end
            end
            qsah_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {5'b0, conf_reg, score_reg, bad_reg, count_reg, ev_reg};
                    out_valid_next = 1'b1;
                    st_next        = qsah_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = qsah_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
